@@ hdl/sctg_pkg.sv @@
// Shared types, constants and control word decode for the servo target guard.
package sctg_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_REQ_VALID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP  = 2'd2;

  localparam logic [31:0] REQ_VALID_RST = 32'd100;
  localparam logic [30:0] MAX_JUMP_RST  = 31'd7282;
  localparam logic [30:0] MAX_STEP_RST  = 31'd3;

  localparam logic [15:0] DS_MASK = 16'h006F;

  localparam logic [6:0] DS_FAULT        = 7'h08;
  localparam logic [6:0] DS_SW_ON_DIS    = 7'h40;
  localparam logic [6:0] DS_READY_SW_ON  = 7'h21;
  localparam logic [6:0] DS_SWITCHED_ON  = 7'h23;
  localparam logic [6:0] DS_OP_ENABLED   = 7'h27;

  localparam logic [7:0] CTRL_FAULT_ACK  = 8'h80;
  localparam logic [7:0] CTRL_PREPARE    = 8'h06;
  localparam logic [7:0] CTRL_ARM        = 8'h07;
  localparam logic [7:0] CTRL_ENABLE_OP  = 8'h0F;
  localparam logic [7:0] CTRL_IDLE       = 8'h00;

  typedef struct packed {
    logic [31:0] req_valid;
    logic [30:0] max_jump;
    logic [30:0] max_step;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] actual_position;
    logic signed [31:0] command_position;
    logic [6:0]         state_code;
    logic               frame_valid;
    logic               active;
    logic               activate;
  } item_t;

  function automatic logic [7:0] drive_control(input logic [6:0] ds, input logic seeded);
    logic [7:0] cw;
    case (ds)
      DS_FAULT:       cw = CTRL_FAULT_ACK;
      DS_SW_ON_DIS:   cw = CTRL_PREPARE;
      DS_READY_SW_ON: cw = CTRL_ARM;
      default: begin
        if (ds inside {DS_SWITCHED_ON, DS_OP_ENABLED}) begin
          cw = seeded ? CTRL_ENABLE_OP : CTRL_ARM;
        end else begin
          cw = CTRL_PREPARE;
        end
      end
    endcase
    return cw;
  endfunction

endpackage

@@ hdl/sctg_front.sv @@
// Front end: accepts items, tracks activation edges and classifies each frame.
module sctg_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [31:0]   in_actual_position,
  input  logic [15:0]          in_drive_status,
  input  logic                 in_frame_good,
  input  logic signed [31:0]   in_command_position,
  input  logic                 in_active,
  output sctg_pkg::item_t      item
);
  import sctg_pkg::*;

  logic       active_before_r;
  logic       active_before_nxt;
  logic [15:0] ds_full;

  assign ds_full = in_drive_status & DS_MASK;

  always_comb begin
    item.actual_position  = in_actual_position;
    item.command_position = in_command_position;
    item.state_code       = ds_full[6:0];
    item.frame_valid      = in_frame_good && (in_drive_status != 16'h0000);
    item.active           = in_active;
    item.activate         = in_active && !active_before_r;
  end

  always_comb begin
    active_before_nxt = active_before_r;
    if (in_valid && in_ready) begin
      active_before_nxt = in_active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_before_r <= 1'b0;
    end else begin
      active_before_r <= active_before_nxt;
    end
  end

endmodule

@@ hdl/sctg_queue.sv @@
// Short item queue between the front and back ends.
module sctg_queue #(
  parameter int unsigned DEPTH = sctg_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  sctg_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output sctg_pkg::item_t rd_item
);
  import sctg_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign wr_ready = (count_r != FULL);
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ hdl/sctg_back.sv @@
// Back end: feedback state, jump guard, slew limit and registered result.
module sctg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sctg_pkg::cfg_t      cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  sctg_pkg::item_t     q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_target_position,
  output logic                out_target_valid,
  output logic [7:0]          out_control_word,
  output logic signed [32:0]  out_position_delta,
  output logic                out_command_rejected
);
  import sctg_pkg::*;

  logic               seeded_r, seeded_nxt;
  logic [31:0]        count_r, count_nxt;
  logic signed [31:0] lvp_r, lvp_nxt;
  logic signed [31:0] ht_r, ht_nxt;
  logic signed [32:0] delta_r, delta_nxt;
  logic               ov_r, ov_nxt;
  logic signed [31:0] otp_r;
  logic               otv_r;
  logic [7:0]         ocw_r;
  logic signed [32:0] odl_r;
  logic               orj_r;

  logic               take;
  logic               seeded0;
  logic [31:0]        count0;
  logic signed [31:0] ht0;
  logic               follow;
  logic               rejected;
  logic signed [32:0] jump;
  logic [32:0]        mag;
  logic [30:0]        step;
  logic signed [32:0] step33;
  logic signed [32:0] diff;
  logic signed [31:0] slewed;

  assign q_ready = !ov_r || out_ready;
  assign take    = q_valid && q_ready;

  always_comb begin
    seeded0 = q_item.activate ? 1'b0 : seeded_r;
    count0  = q_item.activate ? '0 : count_r;

    seeded_nxt = seeded0 || q_item.frame_valid;
    if (q_item.frame_valid) begin
      count_nxt = (count0 == '1) ? count0 : count0 + 32'd1;
      lvp_nxt   = q_item.actual_position;
      delta_nxt = seeded0 ? ($signed({q_item.actual_position[31], q_item.actual_position})
                           - $signed({lvp_r[31], lvp_r})) : '0;
    end else begin
      count_nxt = '0;
      lvp_nxt   = lvp_r;
      delta_nxt = delta_r;
    end
    ht0 = (q_item.frame_valid && !seeded0) ? q_item.actual_position : ht_r;

    follow = seeded_nxt && q_item.active && (q_item.state_code == DS_OP_ENABLED)
             && (count_nxt >= cfg.req_valid);
    jump = $signed({q_item.command_position[31], q_item.command_position})
           - $signed({lvp_nxt[31], lvp_nxt});
    mag  = jump[32] ? 33'(-jump) : 33'(jump);
    rejected = follow && (mag > {2'b00, cfg.max_jump});

    step   = (cfg.max_step == '0) ? 31'd1 : cfg.max_step;
    step33 = $signed({2'b00, step});
    diff   = $signed({q_item.command_position[31], q_item.command_position})
             - $signed({ht0[31], ht0});
    if (diff > step33) begin
      slewed = ht0 + $signed({1'b0, step});
    end else if (diff < -step33) begin
      slewed = ht0 - $signed({1'b0, step});
    end else begin
      slewed = q_item.command_position;
    end

    if (!seeded_nxt) begin
      ht_nxt = ht0;
    end else if (!q_item.active) begin
      ht_nxt = q_item.actual_position;
    end else if (follow && !rejected) begin
      ht_nxt = slewed;
    end else begin
      ht_nxt = ht0;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (take) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      seeded_r <= 1'b0;
      count_r  <= '0;
      lvp_r    <= '0;
      ht_r     <= '0;
      delta_r  <= '0;
    end else begin
      ov_r <= ov_nxt;
      if (take) begin
        seeded_r <= seeded_nxt;
        count_r  <= count_nxt;
        lvp_r    <= lvp_nxt;
        ht_r     <= ht_nxt;
        delta_r  <= delta_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      otp_r <= seeded_nxt ? ht_nxt : '0;
      otv_r <= seeded_nxt;
      ocw_r <= q_item.active ? drive_control(q_item.state_code, seeded_nxt) : CTRL_IDLE;
      odl_r <= delta_nxt;
      orj_r <= rejected;
    end
  end

  assign out_valid            = ov_r;
  assign out_target_position  = otp_r;
  assign out_target_valid     = otv_r;
  assign out_control_word     = ocw_r;
  assign out_position_delta   = odl_r;
  assign out_command_rejected = orj_r;

endmodule

@@ hdl/servo_csp_target_guard.sv @@
// Top level of the servo position target guard: config registers, front, queue, back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_ready   | actual_position, drive_status, frame_good,
//           |                       | command_position, active
//  out      | out_valid / out_ready | target_position, target_valid, control_word,
//           |                       | position_delta, command_rejected
//  cfg      | cfg_we                | cfg_index, cfg_data
//
//  One item per clock sustained while out_ready is high; an item's result appears in
//  the cycle after it leaves the queue, via queue memory then the result registers.
//  The back end's per-item state update (run count, target slew) sets this rate.
//  Reset is synchronous; control and state return to defaults, data is not cleared.
//  A stalled output holds its result; the queue keeps taking items until it is full.
module servo_csp_target_guard #(
  parameter int unsigned QUEUE_DEPTH = sctg_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                in_actual_position,
  input  logic [15:0]                       in_drive_status,
  input  logic                              in_frame_good,
  input  logic signed [31:0]                in_command_position,
  input  logic                              in_active,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_target_position,
  output logic                              out_target_valid,
  output logic [7:0]                        out_control_word,
  output logic signed [32:0]                out_position_delta,
  output logic                              out_command_rejected,
  input  logic                              cfg_we,
  input  logic [sctg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sctg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sctg_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  item_t front_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_REQ_VALID: cfg_nxt.req_valid = cfg_data;
        CFG_MAX_JUMP:  cfg_nxt.max_jump  = cfg_data[30:0];
        CFG_MAX_STEP:  cfg_nxt.max_step  = cfg_data[30:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.req_valid <= REQ_VALID_RST;
      cfg_r.max_jump  <= MAX_JUMP_RST;
      cfg_r.max_step  <= MAX_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sctg_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_actual_position  (in_actual_position),
    .in_drive_status     (in_drive_status),
    .in_frame_good       (in_frame_good),
    .in_command_position (in_command_position),
    .in_active           (in_active),
    .item                (front_item)
  );

  sctg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_item  (front_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  sctg_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_ready              (q_ready),
    .q_item               (q_item),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_target_position  (out_target_position),
    .out_target_valid     (out_target_valid),
    .out_control_word     (out_control_word),
    .out_position_delta   (out_position_delta),
    .out_command_rejected (out_command_rejected)
  );

endmodule

@@ test/servo_csp_target_guard_tb.sv @@
// Testbench for servo_csp_target_guard: directed and random servo cycles against a predictor.
`timescale 1ns / 1ps

module servo_csp_target_guard_tb;
  import sctg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [31:0] actual;
    logic [15:0]        status;
    logic               good;
    logic signed [31:0] command;
    logic               act;
  } servo_frame_t;

  typedef struct packed {
    logic signed [31:0] target;
    logic               seeded_flag;
    logic [7:0]         control;
    logic signed [32:0] delta;
    logic               refused;
  } guard_out_t;

  typedef enum {READY_ALWAYS, READY_MOSTLY, READY_PERIODIC, READY_COIN} stall_pattern_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [31:0]    in_actual_position = '0;
  logic [15:0]           in_drive_status = '0;
  logic                  in_frame_good = 1'b0;
  logic signed [31:0]    in_command_position = '0;
  logic                  in_active = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [31:0]    out_target_position;
  logic                  out_target_valid;
  logic [7:0]            out_control_word;
  logic signed [32:0]    out_position_delta;
  logic                  out_command_rejected;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_REQ_VALID;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state and limits
  logic                  is_seeded = 1'b0;
  logic [31:0]           good_run = '0;
  logic signed [31:0]    last_good_pos = '0;
  logic signed [31:0]    tgt_hold = '0;
  logic signed [32:0]    pos_step = '0;
  logic                  was_active = 1'b0;
  logic [31:0]           need_good = REQ_VALID_RST;
  logic [30:0]           jump_lim = MAX_JUMP_RST;
  logic [30:0]           step_lim = MAX_STEP_RST;

  guard_out_t            pending_targets[$];
  int                    errors = 0;
  int                    cycles = 0;
  int                    frames_sent = 0;
  int                    results_checked = 0;
  int                    commands_followed = 0;
  int                    commands_refused = 0;
  int                    burst_left = 0;
  int                    stall_left = 0;
  stall_pattern_t        stall_mode = READY_ALWAYS;

  servo_csp_target_guard dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_actual_position   (in_actual_position),
    .in_drive_status      (in_drive_status),
    .in_frame_good        (in_frame_good),
    .in_command_position  (in_command_position),
    .in_active            (in_active),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_target_position  (out_target_position),
    .out_target_valid     (out_target_valid),
    .out_control_word     (out_control_word),
    .out_position_delta   (out_position_delta),
    .out_command_rejected (out_command_rejected),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_targets.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_pattern_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    case (stall_mode)
      READY_ALWAYS:   out_ready <= 1'b1;
      READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
      READY_PERIODIC: out_ready <= (cycles[2:0] < 3'd5);
      default:        out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  task automatic report_mismatch(input string what, input logic [32:0] got,
                                 input logic [32:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    guard_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_targets.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = pending_targets.pop_front();
        results_checked++;
        if (out_target_position !== want.target)
          report_mismatch("target_position", 33'(out_target_position), 33'(want.target));
        if (out_target_valid !== want.seeded_flag)
          report_mismatch("target_valid", 33'(out_target_valid), 33'(want.seeded_flag));
        if (out_control_word !== want.control)
          report_mismatch("control_word", 33'(out_control_word), 33'(want.control));
        if (out_position_delta !== want.delta)
          report_mismatch("position_delta", out_position_delta, want.delta);
        if (out_command_rejected !== want.refused)
          report_mismatch("command_rejected", 33'(out_command_rejected), 33'(want.refused));
      end
    end
  end

  function automatic logic signed [31:0] slew_toward(input logic signed [31:0] goal,
                                                     input logic signed [31:0] prev,
                                                     input logic [30:0] lim);
    logic signed [33:0] d;
    logic signed [33:0] s;
    s = (lim == 31'd0) ? 34'sd1 : $signed({3'b000, lim});
    d = $signed({{2{goal[31]}}, goal}) - $signed({{2{prev[31]}}, prev});
    if (d > s) return prev + s[31:0];
    if (d < -s) return prev - s[31:0];
    return goal;
  endfunction

  task automatic advance_servo_cycle(input servo_frame_t f);
    logic [6:0]         ds;
    logic               refused;
    logic [7:0]         cw;
    logic signed [33:0] jump;
    logic [33:0]        jump_mag;
    guard_out_t         r;
    ds = 7'(f.status & DS_MASK);
    refused = 1'b0;
    if (f.act && !was_active) begin
      is_seeded = 1'b0;
      good_run = '0;
    end
    was_active = f.act;
    if (f.good && f.status != 16'd0) begin
      if (good_run != 32'hFFFF_FFFF) good_run = good_run + 32'd1;
      if (!is_seeded) begin
        tgt_hold = f.actual;
        last_good_pos = f.actual;
        pos_step = '0;
        is_seeded = 1'b1;
      end else begin
        pos_step = {f.actual[31], f.actual} - {last_good_pos[31], last_good_pos};
        last_good_pos = f.actual;
      end
    end else begin
      good_run = '0;
    end
    if (is_seeded) begin
      if (!f.act) begin
        tgt_hold = f.actual;
      end else if (ds == DS_OP_ENABLED && good_run >= need_good) begin
        jump = $signed({{2{f.command[31]}}, f.command})
             - $signed({{2{last_good_pos[31]}}, last_good_pos});
        jump_mag = jump[33] ? -jump : jump;
        if (jump_mag > {3'b000, jump_lim}) begin
          refused = 1'b1;
          commands_refused++;
        end else begin
          tgt_hold = slew_toward(f.command, tgt_hold, step_lim);
          commands_followed++;
        end
      end
    end
    if (!f.act) begin
      cw = CTRL_IDLE;
    end else begin
      case (ds)
        DS_FAULT:                      cw = CTRL_FAULT_ACK;
        DS_SW_ON_DIS:                  cw = CTRL_PREPARE;
        DS_READY_SW_ON:                cw = CTRL_ARM;
        DS_SWITCHED_ON, DS_OP_ENABLED: cw = is_seeded ? CTRL_ENABLE_OP : CTRL_ARM;
        default:                       cw = CTRL_PREPARE;
      endcase
    end
    r.target = is_seeded ? tgt_hold : 32'sd0;
    r.seeded_flag = is_seeded;
    r.control = cw;
    r.delta = pos_step;
    r.refused = refused;
    pending_targets.push_back(r);
  endtask

  task automatic send_frame(input servo_frame_t f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_actual_position <= f.actual;
    in_drive_status <= f.status;
    in_frame_good <= f.good;
    in_command_position <= f.command;
    in_active <= f.act;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_servo_cycle(f);
    frames_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_targets.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_limits(input logic [31:0] req, input logic [31:0] jmp,
                             input logic [31:0] stp);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_REQ_VALID;
    cfg_data <= req;
    @(posedge clk);
    cfg_index <= CFG_MAX_JUMP;
    cfg_data <= jmp;
    @(posedge clk);
    cfg_index <= CFG_MAX_STEP;
    cfg_data <= stp;
    @(posedge clk);
    cfg_we <= 1'b0;
    need_good = req;
    jump_lim = jmp[30:0];
    step_lim = stp[30:0];
  endtask

  function automatic servo_frame_t mk_frame(input logic signed [31:0] a, input logic [15:0] s,
                                            input logic g, input logic signed [31:0] c,
                                            input logic act);
    servo_frame_t f;
    f.actual = a;
    f.status = s;
    f.good = g;
    f.command = c;
    f.act = act;
    return f;
  endfunction

  function automatic servo_frame_t noise_frame();
    servo_frame_t f;
    f.actual = $urandom();
    f.status = 16'($urandom());
    f.good = 1'($urandom_range(0, 1));
    f.command = $urandom();
    f.act = 1'($urandom_range(0, 1));
    return f;
  endfunction

  function automatic logic [15:0] pick_state();
    case ($urandom_range(0, 19))
      0:       return {9'd0, DS_FAULT};
      1:       return {9'd0, DS_SW_ON_DIS};
      2:       return {9'd0, DS_READY_SW_ON};
      3:       return {9'd0, DS_SWITCHED_ON};
      4:       return 16'($urandom()) & DS_MASK;
      default: return {9'd0, DS_OP_ENABLED};
    endcase
  endfunction

  // aim inside the jump window, right at its edge, or anywhere
  function automatic logic signed [31:0] aim_command(input logic signed [31:0] near);
    longint off;
    longint span;
    span = (jump_lim > 31'd5000) ? 5000 : longint'(jump_lim);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1, 2: begin
        off = longint'(jump_lim) + longint'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 0) off = -off;
      end
      default: off = longint'($urandom_range(0, 32'(2 * span))) - span;
    endcase
    return 32'(longint'(near) + off);
  endfunction

  task automatic run_traffic(input int n_items, input int noise_pct, input int len_lo,
                             input int len_hi);
    int                 sent;
    int                 len;
    int                 lead;
    int                 bad_pct;
    int                 drop_pct;
    logic signed [31:0] pos;
    servo_frame_t       f;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(len_lo, len_hi);
      lead = $urandom_range(0, 3);
      bad_pct = ($urandom_range(0, 2) == 0) ? 8 : 0;
      drop_pct = (bad_pct != 0) ? 3 : 0;
      pos = $urandom();
      for (int i = 0; i < len && sent < n_items; i++) begin
        if ($urandom_range(0, 99) < noise_pct) begin
          f = noise_frame();
        end else begin
          pos = pos + $urandom_range(0, 40) - 20;
          f.actual = pos;
          f.status = (16'($urandom()) & ~DS_MASK) | pick_state();
          f.good = ($urandom_range(0, 99) >= bad_pct);
          f.act = (i >= lead) && ($urandom_range(0, 99) >= drop_pct);
          f.command = aim_command(pos);
        end
        send_frame(f);
        sent++;
      end
    end
  endtask

  // reset limits: commands never followed, so this walks seeding, delta and control decode
  task automatic test_feedback_paths();
    send_frame(mk_frame(32'sd0, 16'h0000, 1'b1, 32'sd0, 1'b0));
    send_frame(mk_frame(32'sh7FFF_FFFF, 16'h0040, 1'b0, 32'sh7FFF_FFFF, 1'b0));
    send_frame(mk_frame(32'sh8000_0000, 16'h0021, 1'b1, 32'sd5, 1'b0));
    send_frame(mk_frame(32'sh7FFF_FFFF, 16'hFFFF, 1'b1, 32'sh8000_0000, 1'b0));
    send_frame(mk_frame(32'sh8000_0000, 16'h0008, 1'b1, 32'sd0, 1'b0));
    send_frame(mk_frame(32'sd100, 16'h0023, 1'b0, 32'sd0, 1'b1));
    send_frame(mk_frame(32'sd100, 16'h0027, 1'b1, 32'sd300, 1'b1));
    send_frame(mk_frame(32'sd105, 16'h0023, 1'b1, 32'sd0, 1'b1));
    send_frame(mk_frame(32'sd105, 16'h0008, 1'b1, 32'sd0, 1'b1));
    send_frame(mk_frame(32'sd105, 16'h0040, 1'b1, 32'sd0, 1'b1));
    send_frame(mk_frame(32'sd105, 16'h0021, 1'b1, 32'sd0, 1'b1));
    send_frame(mk_frame(32'sd105, 16'hFF90, 1'b1, 32'sd0, 1'b1));
    send_frame(mk_frame(32'sd110, 16'hFFB7, 1'b1, 32'sd0, 1'b1));
    send_frame(mk_frame(-32'sd7, 16'h0027, 1'b1, 32'sd0, 1'b0));
    send_frame(mk_frame(-32'sd9, 16'h0027, 1'b0, 32'sd0, 1'b0));
  endtask

  task automatic test_command_guard();
    load_limits(32'd0, 32'd5, 32'd0);
    send_frame(mk_frame(32'sd1000, 16'h0027, 1'b0, 32'sd1000, 1'b1));
    send_frame(mk_frame(32'sd1000, 16'h0027, 1'b1, 32'sd1003, 1'b1));
    send_frame(mk_frame(32'sd1000, 16'h0027, 1'b1, 32'sd1006, 1'b1));
    send_frame(mk_frame(32'sd1000, 16'h0027, 1'b1, 32'sd995, 1'b1));
    load_limits(32'd0, 32'd0, 32'd10);
    send_frame(mk_frame(32'sd1000, 16'h0027, 1'b1, 32'sd1000, 1'b1));
    send_frame(mk_frame(32'sd1000, 16'h0027, 1'b1, 32'sd1001, 1'b1));
    load_limits(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(mk_frame(32'sh8000_0000, 16'h0027, 1'b1, 32'sh7FFF_FFFF, 1'b1));
    send_frame(mk_frame(32'sd0, 16'h0027, 1'b1, 32'sh7FFF_FFFF, 1'b1));
    send_frame(mk_frame(32'sd0, 16'h0027, 1'b1, 32'sh8000_0000, 1'b1));
    send_frame(mk_frame(32'sd0, 16'h0027, 1'b1, -32'sd2147483647, 1'b1));
    send_frame(mk_frame(32'sd50, 16'h0027, 1'b0, 32'sd3, 1'b1));
  endtask

  task automatic test_counted_enable();
    load_limits(REQ_VALID_RST, 32'(MAX_JUMP_RST), 32'(MAX_STEP_RST));
    run_traffic(180, 0, 120, 170);
  endtask

  task automatic test_tight_limits();
    for (int k = 0; k < 5; k++) begin
      load_limits($urandom_range(0, 6), $urandom_range(1, 2000), $urandom_range(1, 50));
      run_traffic(50, 10, 4, 60);
    end
  endtask

  task automatic test_zero_limits();
    load_limits(32'd0, 32'd0, 32'd0);
    run_traffic(120, 10, 4, 40);
  endtask

  task automatic test_wide_limits();
    load_limits(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_traffic(150, 15, 4, 40);
  endtask

  task automatic test_never_enabled();
    load_limits(32'hFFFF_FFFF, 32'd1, 32'd1);
    run_traffic(100, 10, 4, 40);
  endtask

  task automatic test_noise();
    load_limits($urandom_range(0, 3), $urandom(), $urandom());
    run_traffic(150, 70, 2, 20);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_feedback_paths();
    test_command_guard();
    test_counted_enable();
    test_tight_limits();
    test_zero_limits();
    test_wide_limits();
    test_never_enabled();
    test_noise();
    drain();
    repeat (10) @(posedge clk);
    if (pending_targets.size() != 0)
      report_mismatch("results never delivered", 33'(pending_targets.size()), '0);
    $display("covered %0d frames, %0d results checked; %0d commands followed, %0d refused",
             frames_sent, results_checked, commands_followed, commands_refused);
    $display("limits ran at reset, zero, small and full width values with both sides stalling");
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
